### design/sha_pkg.sv
package sha_pkg;

    localparam int unsigned CountW = 61;

    typedef logic [31:0] t_word;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       byte_present;
        logic       end_of_message;
    } t_in_item;

    typedef struct packed {
        logic [31:0] digest_word;
        logic [2:0]  word_index;
        logic        last_word;
    } t_out_item;

    // handshake between the controller and the round engine
    typedef struct packed {
        logic start;
        logic busy;
        logic done;
    } t_eng_ctl;

    function automatic t_word k_const(input logic [5:0] idx);
        t_word k;
        unique case (idx)
            6'd0: k = 32'h428a2f98; 6'd1: k = 32'h71374491; 6'd2: k = 32'hb5c0fbcf;
            6'd3: k = 32'he9b5dba5; 6'd4: k = 32'h3956c25b; 6'd5: k = 32'h59f111f1;
            6'd6: k = 32'h923f82a4; 6'd7: k = 32'hab1c5ed5; 6'd8: k = 32'hd807aa98;
            6'd9: k = 32'h12835b01; 6'd10: k = 32'h243185be; 6'd11: k = 32'h550c7dc3;
            6'd12: k = 32'h72be5d74; 6'd13: k = 32'h80deb1fe; 6'd14: k = 32'h9bdc06a7;
            6'd15: k = 32'hc19bf174; 6'd16: k = 32'he49b69c1; 6'd17: k = 32'hefbe4786;
            6'd18: k = 32'h0fc19dc6; 6'd19: k = 32'h240ca1cc; 6'd20: k = 32'h2de92c6f;
            6'd21: k = 32'h4a7484aa; 6'd22: k = 32'h5cb0a9dc; 6'd23: k = 32'h76f988da;
            6'd24: k = 32'h983e5152; 6'd25: k = 32'ha831c66d; 6'd26: k = 32'hb00327c8;
            6'd27: k = 32'hbf597fc7; 6'd28: k = 32'hc6e00bf3; 6'd29: k = 32'hd5a79147;
            6'd30: k = 32'h06ca6351; 6'd31: k = 32'h14292967; 6'd32: k = 32'h27b70a85;
            6'd33: k = 32'h2e1b2138; 6'd34: k = 32'h4d2c6dfc; 6'd35: k = 32'h53380d13;
            6'd36: k = 32'h650a7354; 6'd37: k = 32'h766a0abb; 6'd38: k = 32'h81c2c92e;
            6'd39: k = 32'h92722c85; 6'd40: k = 32'ha2bfe8a1; 6'd41: k = 32'ha81a664b;
            6'd42: k = 32'hc24b8b70; 6'd43: k = 32'hc76c51a3; 6'd44: k = 32'hd192e819;
            6'd45: k = 32'hd6990624; 6'd46: k = 32'hf40e3585; 6'd47: k = 32'h106aa070;
            6'd48: k = 32'h19a4c116; 6'd49: k = 32'h1e376c08; 6'd50: k = 32'h2748774c;
            6'd51: k = 32'h34b0bcb5; 6'd52: k = 32'h391c0cb3; 6'd53: k = 32'h4ed8aa4a;
            6'd54: k = 32'h5b9cca4f; 6'd55: k = 32'h682e6ff3; 6'd56: k = 32'h748f82ee;
            6'd57: k = 32'h78a5636f; 6'd58: k = 32'h84c87814; 6'd59: k = 32'h8cc70208;
            6'd60: k = 32'h90befffa; 6'd61: k = 32'ha4506ceb; 6'd62: k = 32'hbef9a3f7;
            default: k = 32'hc67178f2;
        endcase
        return k;
    endfunction

    function automatic t_word h_init(input logic [2:0] idx);
        t_word h;
        unique case (idx)
            3'd0: h = 32'h6a09e667; 3'd1: h = 32'hbb67ae85;
            3'd2: h = 32'h3c6ef372; 3'd3: h = 32'ha54ff53a;
            3'd4: h = 32'h510e527f; 3'd5: h = 32'h9b05688c;
            3'd6: h = 32'h1f83d9ab; default: h = 32'h5be0cd19;
        endcase
        return h;
    endfunction

    function automatic t_word ror(input t_word x, input int unsigned n);
        return (x >> n) | (x << (32 - n));
    endfunction

endpackage

### design/sha_stream_if.sv
interface sha_in_if;
    logic              valid;
    logic              ready;
    sha_pkg::t_in_item payload;
    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

interface sha_out_if;
    logic               valid;
    logic               ready;
    sha_pkg::t_out_item payload;
    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

### design/sha256_stream_hasher_top.sv
// channel  | dir | payload
// in_ch    | in  | data_byte[8], byte_present, end_of_message
// out_ch   | out | digest_word[32], word_index[3], last_word
// A byte is accepted whenever the controller is idle; each full block holds
// input off while the single round unit runs 64 rounds.
// End of message adds one to sixteen padding-word writes per padded block
// plus one or two compressions,
// then eight output transactions, each held until the sink is ready.
// Synchronous active-low reset restores the initial hash and zero count.
module sha256_stream_hasher_top (
    input logic        i_clk,
    input logic        i_rst_n,
    sha_in_if.sink     in_ch,
    sha_out_if.source  out_ch
);
    sha_pkg::t_eng_ctl eng;
    logic              busy, done;
    logic [3:0]        addr;
    sha_pkg::t_word    blk, h [8], v [8];

    sha_engine u_eng (
        .i_clk, .i_rst_n, .i_start(eng.start), .o_busy(busy), .o_done(done),
        .o_blk_addr(addr), .i_blk_data(blk), .i_h(h), .o_v(v)
    );

    sha_ctrl u_ctrl (
        .i_clk, .i_rst_n, .in_ch, .out_ch, .o_eng(eng), .i_eng_busy(busy),
        .i_eng_done(done), .i_eng_addr(addr), .o_blk_data(blk), .o_h(h), .i_v(v)
    );

    a_no_in_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        busy |-> !in_ch.ready) else $error("input taken during compression");
    a_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        eng.start |-> !$past(busy)) else $error("start while busy");
    a_no_out_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        busy |-> !out_ch.valid) else $error("output during compression");
endmodule

### design/sha_engine.sv
// 64-round compression; message schedule kept as a 16-word shift window
// fed from the block buffer memory read port.
module sha_engine (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    output logic          o_busy,
    output logic          o_done,
    // block buffer read port (registered data)
    output logic [3:0]    o_blk_addr,
    input  sha_pkg::t_word i_blk_data,
    // chain value words
    input  sha_pkg::t_word i_h [8],
    output sha_pkg::t_word o_v [8]
);
    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_RUN  = 2'd1;
    localparam logic [1:0] S_FIN  = 2'd2;

    logic [1:0]     r_state;
    logic [6:0]     r_cnt;
    sha_pkg::t_word r_v [8];
    // rolling schedule window: taps read at fixed places
    sha_pkg::t_word r_w [16];

    logic [5:0]     round;
    sha_pkg::t_word w_cur, s0, s1, w_new, t1, t2, e, a;

    assign o_blk_addr = r_cnt[3:0];
    assign o_busy     = (r_state != S_IDLE);
    assign o_done     = (r_state == S_FIN);
    assign o_v        = r_v;

    // round index lags the read address by one
    assign round = r_cnt[5:0] - 6'd1;

    always_comb begin
        s0    = sha_pkg::ror(r_w[1], 7) ^ sha_pkg::ror(r_w[1], 18) ^ (r_w[1] >> 3);
        s1    = sha_pkg::ror(r_w[14], 17) ^ sha_pkg::ror(r_w[14], 19) ^ (r_w[14] >> 10);
        w_new = r_w[0] + s0 + r_w[9] + s1;
        w_cur = (r_cnt <= 7'd16) ? i_blk_data : w_new;
        e     = r_v[4];
        a     = r_v[0];
        t1    = r_v[7] + (sha_pkg::ror(e, 6) ^ sha_pkg::ror(e, 11) ^ sha_pkg::ror(e, 25))
              + ((e & r_v[5]) ^ (~e & r_v[6])) + sha_pkg::k_const(round) + w_cur;
        t2    = (sha_pkg::ror(a, 2) ^ sha_pkg::ror(a, 13) ^ sha_pkg::ror(a, 22))
              + ((a & r_v[1]) ^ (a & r_v[2]) ^ (r_v[1] & r_v[2]));
    end

    // sequence the rounds
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
        end else begin
            unique case (r_state)
                S_IDLE: if (i_start) begin
                    r_state <= S_RUN;
                    r_cnt   <= 7'd0;
                end
                S_RUN: begin
                    r_cnt <= r_cnt + 7'd1;
                    if (r_cnt == 7'd64) r_state <= S_FIN;
                end
                S_FIN: r_state <= S_IDLE;
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // working variables and schedule window
    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && i_start) begin
            r_v <= i_h;
        end else if (r_state == S_RUN && r_cnt != 7'd0) begin
            r_v[7] <= r_v[6];
            r_v[6] <= r_v[5];
            r_v[5] <= e;
            r_v[4] <= r_v[3] + t1;
            r_v[3] <= r_v[2];
            r_v[2] <= r_v[1];
            r_v[1] <= a;
            r_v[0] <= t1 + t2;
            for (int i = 0; i < 15; i++) r_w[i] <= r_w[i+1];
            r_w[15] <= w_cur;
        end
    end
endmodule

### design/sha_ctrl.sv
// Byte packing into the block buffer memory, padding and digest emission.
module sha_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    sha_in_if.sink         in_ch,
    sha_out_if.source      out_ch,
    output sha_pkg::t_eng_ctl o_eng,
    input  logic           i_eng_busy,
    input  logic           i_eng_done,
    input  logic [3:0]     i_eng_addr,
    output sha_pkg::t_word o_blk_data,
    output sha_pkg::t_word o_h [8],
    input  sha_pkg::t_word i_v [8]
);
    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_PAD  = 3'd1;
    localparam logic [2:0] S_WAIT = 3'd3;
    localparam logic [2:0] S_OUT  = 3'd4;

    logic [2:0]                r_state;
    logic [sha_pkg::CountW-1:0] r_count;
    logic [5:0]                r_pos;      // padding write position
    logic                      r_final;    // current compression closes message
    logic                      r_emit_after;
    logic                      r_mark;     // 0x80 byte still to be placed
    logic [2:0]                r_oidx;
    logic                      r_start;
    sha_pkg::t_word            r_h [8];
    sha_pkg::t_word            r_acc;      // partial word being packed

    // block buffer memory
    sha_pkg::t_word            mem [16];
    sha_pkg::t_word            r_rd;
    logic                      we;
    logic [3:0]                wa;
    sha_pkg::t_word            wd;

    logic                      take, put, fin;
    logic [5:0]                bpos;
    logic [63:0]               bits;
    sha_pkg::t_word            pad_word;

    assign in_ch.ready = (r_state == S_IDLE);
    always_comb take = in_ch.valid & in_ch.ready;
    assign put  = take & in_ch.payload.byte_present;
    assign fin  = take & in_ch.payload.end_of_message;
    assign bpos = r_count[5:0];
    assign bits = {r_count, 3'b000};

    always_ff @(posedge i_clk) begin
        if (we) mem[wa] <= wd;
        r_rd <= mem[i_eng_addr];
    end
    assign o_blk_data = r_rd;
    assign o_h        = r_h;
    assign o_eng      = '{start: r_start, busy: i_eng_busy, done: i_eng_done};

    // word for padding position r_pos: the 0x80 marker merged into the
    // partial word first, then zeros, with the bit length in the last two words of the final block
    always_comb begin
        pad_word = '0;
        if (r_mark) begin
            case (r_pos[1:0])
                2'd0: pad_word = {8'h80, 24'h0};
                2'd1: pad_word = {r_acc[31:24], 8'h80, 16'h0};
                2'd2: pad_word = {r_acc[31:16], 8'h80, 8'h0};
                default: pad_word = {r_acc[31:8], 8'h80};
            endcase
        end else if (r_pos[5:2] == 4'd14 && r_final && !r_emit_after) begin
            pad_word = bits[63:32];
        end else if (r_pos[5:2] == 4'd15 && r_final && !r_emit_after) begin
            pad_word = bits[31:0];
        end
    end

    // memory write selection
    always_comb begin
        we = 1'b0;
        wa = bpos[5:2];
        wd = r_acc;
        if (put) begin
            we = 1'b1;
            wa = bpos[5:2];
            unique case (bpos[1:0])
                2'd0: wd = {in_ch.payload.data_byte, 24'h0};
                2'd1: wd = {r_acc[31:24], in_ch.payload.data_byte, 16'h0};
                2'd2: wd = {r_acc[31:16], in_ch.payload.data_byte, 8'h0};
                default: wd = {r_acc[31:8], in_ch.payload.data_byte};
            endcase
        end else if (r_state == S_PAD) begin
            we = 1'b1;
            wa = r_pos[5:2];
            wd = pad_word;
        end
    end

    always_ff @(posedge i_clk) begin
        if (put) r_acc <= wd;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_start <= 1'b0;
            r_oidx  <= '0;
            r_final <= 1'b0;
            r_emit_after <= 1'b0;
            r_mark  <= 1'b0;
            r_pos   <= '0;
            for (int i = 0; i < 8; i++) r_h[i] <= sha_pkg::h_init(3'(i));
        end else begin
            r_start <= 1'b0;
            unique case (r_state)
                S_IDLE: if (take) begin
                    logic [sha_pkg::CountW-1:0] c;
                    logic [5:0] p;
                    c = put ? r_count + 1'b1 : r_count;
                    r_count <= c;
                    p = c[5:0];
                    if (put && bpos == 6'd63) begin
                        // full block: compress, then pad if ending
                        r_final      <= 1'b0;
                        r_emit_after <= fin;
                        r_mark       <= fin;
                        r_start      <= 1'b1;
                        r_state      <= S_WAIT;
                    end else if (fin) begin
                        // end of message: pad this block, and one more if no room for the length
                        r_state <= S_PAD;
                        r_final <= (p < 6'd56);
                        r_emit_after <= (p >= 6'd56);
                        r_mark  <= 1'b1;
                        r_pos   <= p;
                    end
                end
                S_PAD: begin
                    // first step writes 0x80 into partial word while r_mark is set
                    r_mark <= 1'b0;
                    r_pos <= {r_pos[5:2] + 4'd1, 2'b00};
                    if (r_pos[5:2] == 4'd15) begin
                        r_start <= 1'b1;
                        r_state <= S_WAIT;
                    end
                end
                S_WAIT: if (i_eng_done) begin
                    for (int i = 0; i < 8; i++) r_h[i] <= r_h[i] + i_v[i];
                    if (r_emit_after) begin
                        r_emit_after <= 1'b0;
                        r_final <= 1'b1;
                        r_pos   <= 6'd0;
                        r_state <= S_PAD;
                    end else if (r_final) begin
                        r_oidx  <= '0;
                        r_state <= S_OUT;
                    end else begin
                        r_state <= S_IDLE;
                    end
                end
                S_OUT: if (out_ch.ready) begin
                    r_oidx <= r_oidx + 3'd1;
                    if (r_oidx == 3'd7) begin
                        r_state <= S_IDLE;
                        r_count <= '0;
                        r_final <= 1'b0;
                        for (int i = 0; i < 8; i++) r_h[i] <= sha_pkg::h_init(3'(i));
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign out_ch.valid = (r_state == S_OUT);
    assign out_ch.payload = '{digest_word: r_h[r_oidx], word_index: r_oidx,
                              last_word: (r_oidx == 3'd7)};
endmodule
